FILE: hdl/derq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended ring queue package
// Shared field widths, operation and status codes, and the result layout.
// ----------------------------------------------------------------------------
package derq_pkg;

    localparam int KIND_W      = 3;
    localparam int ENTRY_W     = 32;
    localparam int INDEX_W     = 6;
    localparam int STATUS_W    = 2;
    localparam int RING_SIZE_W = 7;

    // Packed result: 85 bits of fields padded to whole bytes.
    localparam int RESULT_W = STATUS_W + 2 * ENTRY_W + 3 * INDEX_W + 1;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int PAD_W     = M_TDATA_W - RESULT_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_QUERY      = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Listed from the highest bit down; status sits in the lowest bits.
    typedef struct packed {
        logic [PAD_W-1:0]   pad;
        logic               empty_flag;
        logic [INDEX_W-1:0] free_slots;
        logic [INDEX_W-1:0] back_index;
        logic [INDEX_W-1:0] front_index;
        logic [ENTRY_W-1:0] back_entry;
        logic [ENTRY_W-1:0] front_entry;
        status_t            status;
    } result_t;

endpackage

FILE: hdl/double_ended_ring_queue.sv
// ----------------------------------------------------------------------------
// Double-ended ring queue
// Ring buffer deque with push and pop at both ends and a per-transaction
// status report.
// ----------------------------------------------------------------------------
// Channel   Dir  Bits  Contents (lowest bit first)
// s_        in   32/3  tdata: entry_data; tuser: kind
// m_        out  88    tdata: status, front_entry, back_entry, front_index,
//                      back_index, free_slots, empty_flag, zero pad
// cfg_wr_*  in   7     ring_size
//
// One transaction is accepted per cycle while the result is not stalled; its
// result appears in the next cycle, from the registered read of the entry RAM.
// Reset empties the queue and sets the ring size to 64 (or DEPTH if smaller).
// A ring size write empties the queue too.
// A stalled result holds the output register and the input side waits with it.
// ----------------------------------------------------------------------------
module double_ended_ring_queue
    import derq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [ENTRY_W-1:0]     s_tdata,     // entry_data
    input  logic [KIND_W-1:0]      s_tuser,     // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,     // status, front_entry, back_entry,
                                                // front_index, back_index,
                                                // free_slots, empty_flag, pad
    input  logic                   cfg_wr_en,
    input  logic [RING_SIZE_W-1:0] cfg_wr_data  // ring_size
);

    localparam int IW   = $clog2(DEPTH);
    localparam int SW   = $clog2(DEPTH + 1);
    localparam int CMPW = (SW > RING_SIZE_W) ? SW : RING_SIZE_W;
    localparam int RESET_SIZE = (DEPTH < 64) ? DEPTH : 64;

    // Ring state.
    logic [IW-1:0] front_reg, front_next;
    logic [IW-1:0] back_reg, back_next;
    logic [IW-1:0] last_reg, last_next;   // effective ring size minus one
    logic [SW-1:0] size_reg, size_next;

    // Result stage.
    logic                  m_valid_reg, m_valid_next;
    status_t               status_reg, status_next;
    logic [IW-1:0]         front_q_reg, back_q_reg;
    logic [IW-1:0]         free_reg, free_next;
    logic                  empty_reg, empty_next;
    logic                  byp_a_reg, byp_a_next;
    logic                  byp_b_reg, byp_b_next;
    logic [DATA_WIDTH-1:0] wdata_reg;

    logic                  accept;
    kind_t                 kind;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         rd_addr_b;
    logic [DATA_WIDTH-1:0] rd_data_a, rd_data_b;
    logic                  full;
    logic [CMPW-1:0]       cfg_ext;
    result_t               result;

    function automatic logic [IW-1:0] step_fwd(input logic [IW-1:0] p,
                                               input logic [IW-1:0] last);
        return (p == last) ? '0 : p + IW'(1);
    endfunction

    function automatic logic [IW-1:0] step_back(input logic [IW-1:0] p,
                                                input logic [IW-1:0] last);
        return (p == '0) ? last : p - IW'(1);
    endfunction

    // Entries held between front and back, taken modulo the ring size.
    function automatic logic [SW-1:0] held(input logic [IW-1:0] f,
                                           input logic [IW-1:0] b,
                                           input logic [SW-1:0] size);
        logic [SW-1:0] diff;
        diff = SW'(b) - SW'(f);
        return (b < f) ? diff + size : diff;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;
    assign kind     = kind_t'(s_tuser);
    assign wdata    = DATA_WIDTH'(s_tdata);
    assign full     = (held(front_reg, back_reg, size_reg) == SW'(last_reg));

    // The effective size is the written value clamped to 2..DEPTH.
    assign cfg_ext = CMPW'(cfg_wr_data);
    always_comb begin
        if (cfg_ext < CMPW'(2)) begin
            size_next = SW'(2);
        end else if (cfg_ext > CMPW'(DEPTH)) begin
            size_next = SW'(DEPTH);
        end else begin
            size_next = SW'(cfg_ext);
        end
        last_next = IW'(size_next - SW'(1));
    end

    always_comb begin
        front_next  = front_reg;
        back_next   = back_reg;
        status_next = ST_DONE;
        wr_en       = 1'b0;
        wr_addr     = back_reg;
        case (kind)
            KIND_PUSH_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    front_next = step_back(front_reg, last_reg);
                    wr_en      = 1'b1;
                    wr_addr    = front_next;
                end
            end
            KIND_PUSH_BACK: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    back_next = step_fwd(back_reg, last_reg);
                    wr_en     = 1'b1;
                    wr_addr   = back_reg;
                end
            end
            KIND_POP_FRONT: begin
                if (front_reg == back_reg) begin
                    status_next = ST_EMPTY;
                end else begin
                    front_next = step_fwd(front_reg, last_reg);
                end
            end
            KIND_POP_BACK: begin
                if (front_reg == back_reg) begin
                    status_next = ST_EMPTY;
                end else begin
                    back_next = step_back(back_reg, last_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign rd_addr_b = step_back(back_next, last_reg);

    // The RAM returns old data on a same-cycle read of the written slot,
    // so such reads take the pushed word from the result stage instead.
    always_comb begin
        free_next    = IW'(SW'(last_reg) - held(front_next, back_next, size_reg));
        empty_next   = (front_next == back_next);
        byp_a_next   = wr_en && (wr_addr == front_next);
        byp_b_next   = wr_en && (wr_addr == rd_addr_b);
        m_valid_next = accept ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    derq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk       (aclk),
        .wr_en     (accept && wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wdata),
        .rd_en     (accept),
        .rd_addr_a (front_next),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= '0;
            back_reg    <= '0;
            size_reg    <= SW'(RESET_SIZE);
            last_reg    <= IW'(RESET_SIZE - 1);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                front_reg <= '0;
                back_reg  <= '0;
                size_reg  <= size_next;
                last_reg  <= last_next;
            end else if (accept) begin
                front_reg <= front_next;
                back_reg  <= back_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            front_q_reg <= front_next;
            back_q_reg  <= back_next;
            free_reg    <= free_next;
            empty_reg   <= empty_next;
            byp_a_reg   <= byp_a_next;
            byp_b_reg   <= byp_b_next;
            wdata_reg   <= wdata;
        end
    end

    always_comb begin
        result             = '0;
        result.status      = status_reg;
        result.front_index = INDEX_W'(front_q_reg);
        result.back_index  = INDEX_W'(back_q_reg);
        result.free_slots  = INDEX_W'(free_reg);
        result.empty_flag  = empty_reg;
        if (!empty_reg) begin
            result.front_entry = ENTRY_W'(byp_a_reg ? wdata_reg : rd_data_a);
            result.back_entry  = ENTRY_W'(byp_b_reg ? wdata_reg : rd_data_b);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result;

endmodule

FILE: hdl/derq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered on read enable.
// ----------------------------------------------------------------------------
module derq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

FILE: hdl/derq_checker.sv
// ----------------------------------------------------------------------------
// Double-ended ring queue checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module derq_checker
    import derq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    result_t r;
    assign r = result_t'(m_tdata);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_empty_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.empty_flag |->
            r.front_index == r.back_index && r.front_entry == '0 && r.back_entry == '0)
        else $error("empty result is inconsistent");

    a_full_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.status == ST_FULL |-> r.free_slots == '0 && !r.empty_flag)
        else $error("push refused with free slots");

    a_empty_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.status == ST_EMPTY |-> r.empty_flag)
        else $error("pop refused on a queue that is not empty");

endmodule

bind double_ended_ring_queue derq_checker u_derq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/tb_double_ended_ring_queue.sv
// ----------------------------------------------------------------------------
// Double-ended ring queue testbench
// Drives push, pop and query transactions at both ends over a range of ring
// sizes and handshake pressures. A scoreboard keeps its own copy of the ring
// and indices, predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module tb_double_ended_ring_queue;
    import derq_pkg::*;

    localparam int RING_DEPTH  = 64;
    localparam int PHASE_COUNT = 12;
    localparam int PHASE_ITEMS = 75;

    class ring_queue_scoreboard;
        logic [ENTRY_W-1:0] slots [RING_DEPTH];
        int unsigned        front_q;
        int unsigned        back_q;
        logic [RING_SIZE_W-1:0] ring_size_q;
        result_t            awaited [$];
        int                 errors;
        int                 accepted;
        int                 checked;
        int                 full_refusals;
        int                 empty_refusals;

        function new();
            ring_size_q    = 7'd64;
            front_q        = 0;
            back_q         = 0;
            errors         = 0;
            accepted       = 0;
            checked        = 0;
            full_refusals  = 0;
            empty_refusals = 0;
        endfunction

        function void write_ring_size(logic [RING_SIZE_W-1:0] value);
            ring_size_q = value;
            front_q     = 0;
            back_q      = 0;
        endfunction

        function int unsigned ring_span();
            int unsigned s;
            s = 32'(ring_size_q);
            if (s < 2) s = 2;
            if (s > RING_DEPTH) s = RING_DEPTH;
            return s;
        endfunction

        function int unsigned step_fwd(int unsigned p, int unsigned s);
            return (p + 1 >= s) ? 0 : p + 1;
        endfunction

        function int unsigned step_bwd(int unsigned p, int unsigned s);
            return (p == 0 || p >= s) ? s - 1 : p - 1;
        endfunction

        function int unsigned occupancy(int unsigned s);
            if (back_q >= front_q) return back_q - front_q;
            return s - (front_q - back_q);
        endfunction

        // Applies one accepted transaction to the shadow ring and queues the
        // result it must produce.
        function void note_input(logic [KIND_W-1:0] kind, logic [ENTRY_W-1:0] data);
            int unsigned s;
            int unsigned held;
            bit          no_entries;
            result_t     want;
            s = ring_span();
            if (front_q >= s) front_q = 0;
            if (back_q >= s) back_q = 0;
            held       = occupancy(s);
            no_entries = (front_q == back_q);
            want        = '0;
            want.status = ST_DONE;
            case (kind)
                KIND_PUSH_FRONT: begin
                    if (held >= s - 1) begin
                        want.status = ST_FULL;
                    end else begin
                        front_q        = step_bwd(front_q, s);
                        slots[front_q] = data;
                    end
                end
                KIND_PUSH_BACK: begin
                    if (held >= s - 1) begin
                        want.status = ST_FULL;
                    end else begin
                        slots[back_q] = data;
                        back_q        = step_fwd(back_q, s);
                    end
                end
                KIND_POP_FRONT: begin
                    if (no_entries) want.status = ST_EMPTY;
                    else front_q = step_fwd(front_q, s);
                end
                KIND_POP_BACK: begin
                    if (no_entries) want.status = ST_EMPTY;
                    else back_q = step_bwd(back_q, s);
                end
                default: ;
            endcase
            if (want.status == ST_FULL) full_refusals++;
            if (want.status == ST_EMPTY) empty_refusals++;
            held       = occupancy(s);
            no_entries = (front_q == back_q);
            want.front_entry = no_entries ? '0 : slots[front_q];
            want.back_entry  = no_entries ? '0 : slots[step_bwd(back_q, s)];
            want.front_index = INDEX_W'(front_q);
            want.back_index  = INDEX_W'(back_q);
            want.free_slots  = INDEX_W'((s - 1) - held);
            want.empty_flag  = no_entries;
            awaited.push_back(want);
            accepted++;
        endfunction

        function void compare_field(string name, logic [ENTRY_W-1:0] want,
                                    logic [ENTRY_W-1:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] raw);
            result_t got;
            result_t want;
            got = result_t'(raw);
            if (awaited.size() == 0) begin
                $error("result transaction with no prediction waiting: 0x%0h", raw);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare_field("status", ENTRY_W'(want.status), ENTRY_W'(got.status));
            compare_field("front_entry", want.front_entry, got.front_entry);
            compare_field("back_entry", want.back_entry, got.back_entry);
            compare_field("front_index", ENTRY_W'(want.front_index),
                          ENTRY_W'(got.front_index));
            compare_field("back_index", ENTRY_W'(want.back_index),
                          ENTRY_W'(got.back_index));
            compare_field("free_slots", ENTRY_W'(want.free_slots),
                          ENTRY_W'(got.free_slots));
            compare_field("empty_flag", ENTRY_W'(want.empty_flag),
                          ENTRY_W'(got.empty_flag));
            compare_field("pad", ENTRY_W'(want.pad), ENTRY_W'(got.pad));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ENTRY_W-1:0]     s_tdata;     // entry_data
    logic [KIND_W-1:0]      s_tuser;     // kind
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;     // status, front_entry, back_entry,
                                         // front_index, back_index,
                                         // free_slots, empty_flag, pad
    logic                   cfg_wr_en;
    logic [RING_SIZE_W-1:0] cfg_wr_data; // ring_size

    ring_queue_scoreboard sb = new();

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_off_req    = 0;

    double_ended_ring_queue #(
        .DEPTH      (RING_DEPTH),
        .DATA_WIDTH (ENTRY_W)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: checks each accepted transaction and decides tready for
    // the next edge, with a counted hold-off when one is requested.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_off_req > 0) begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one transaction and returns at the edge that accepts it, with
    // tvalid still high so back-to-back transactions need no gap.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ENTRY_W-1:0] data);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, data);
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_ring_size(input logic [RING_SIZE_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.write_ring_size(value);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random(input int push_pct);
        int                 roll;
        logic [KIND_W-1:0]  kind;
        logic [ENTRY_W-1:0] data;
        roll = $urandom_range(99);
        if (roll < push_pct)
            kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        else if (roll < 90)
            kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
        else if (roll < 96)
            kind = KIND_QUERY;
        else
            kind = KIND_W'($urandom_range((1 << KIND_W) - 1, int'(KIND_QUERY) + 1));
        case ($urandom_range(9))
            0:       data = '0;
            1:       data = '1;
            default: data = $urandom;
        endcase
        send_item(kind, data);
    endtask

    initial begin : stimulus
        logic [RING_SIZE_W-1:0] ring_plan [PHASE_COUNT];
        ring_plan = '{7'd64, 7'd2, 7'd3, 7'd127, 7'd5, 7'd1,
                      7'd63, 7'd17, 7'd0, 7'd100, 7'd8, 7'd33};
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= KIND_QUERY;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty ring at the reset size, then both ends, spare kinds.
        send_item(KIND_QUERY, 32'h1234_5678);
        send_item(KIND_POP_FRONT, '0);
        send_item(KIND_POP_BACK, '1);
        send_item(KIND_PUSH_FRONT, '0);
        send_item(KIND_PUSH_BACK, '1);
        send_item(KIND_PUSH_FRONT, 32'hA5A5_5A5A);
        send_item(KIND_QUERY, '0);
        send_item(KIND_POP_BACK, '0);
        send_item(KIND_POP_FRONT, '0);
        send_item(KIND_POP_FRONT, '0);
        send_item(KIND_POP_BACK, '0);
        for (int k = int'(KIND_QUERY) + 1; k < (1 << KIND_W); k++)
            send_item(KIND_W'(k), '1);

        // A ring size below the minimum acts as two slots, so one entry fills it.
        set_ring_size(7'd0);
        send_item(KIND_PUSH_BACK, '1);
        send_item(KIND_PUSH_FRONT, '0);
        send_item(KIND_PUSH_BACK, 32'h5555_AAAA);
        send_item(KIND_QUERY, '0);
        send_item(KIND_POP_FRONT, '0);
        send_item(KIND_POP_BACK, '0);
        send_item(KIND_PUSH_FRONT, 32'h8000_0001);
        send_item(KIND_POP_BACK, '0);

        // Random phases: fill-biased for the first 42 items, drain-biased for the rest.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_ring_size(ring_plan[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin sender_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 0 && i == 20) hold_off_req = 60;
                if (p == 6 && i == PHASE_ITEMS / 2) drain_results();
                send_random((i < PHASE_ITEMS / 2 + 5) ? 75 : 20);
            end
        end

        drain_results();
        repeat (4) @(posedge aclk);
        $display("Covered %0d transactions over %0d ring size settings; %0d results checked.",
                 sb.accepted, PHASE_COUNT + 2, sb.checked);
        $display("Refused pushes on a full ring: %0d, refused pops on an empty one: %0d.",
                 sb.full_refusals, sb.empty_refusals);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
